/* sv/skit_pkg.sv */
`timescale 1ns / 1ps

package skit_pkg;

  localparam int MODE_W = 2;
  localparam int KEY_W  = 10;
  localparam int POS_W  = 16;
  localparam int ST_W   = 3;
  localparam int USE_W  = 8;

  localparam logic [KEY_W-1:0] KEY_LOW  = 10'd100;
  localparam logic [KEY_W-1:0] KEY_HIGH = 10'd998;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SRCH,
    S_SRCH_CMP,
    S_CHK,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_SHIFT,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    accept;
    logic    srch_rd;
    logic    srch_upd;
    logic    chk_rd;
    logic    ins_start;
    logic    ins_step;
    logic    ins_put;
    logic    del_start;
    logic    del_step;
    logic    dec_count;
    logic    take_pos;
    logic    set_status;
    status_t status_code;
    logic    emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_lookup;
    logic is_insert;
    logic is_delete;
    logic key_bad;
    logic lo_lt_hi;
    logic hit;
    logic full;
    logic ins_has_shift;
    logic ins_more;
    logic del_has_shift;
    logic del_more;
    logic out_busy;
  } stat_t;

endpackage

/* sv/skit_in_if.sv */
`timescale 1ns / 1ps

interface skit_in_if;
  logic                          valid;
  logic                          ready;
  logic [skit_pkg::MODE_W-1:0]   mode;
  logic [skit_pkg::KEY_W-1:0]    search_key;
  logic [skit_pkg::POS_W-1:0]    record_position;

  modport source (output valid, mode, search_key, record_position, input ready);
  modport sink   (input valid, mode, search_key, record_position, output ready);
endinterface

/* sv/skit_out_if.sv */
`timescale 1ns / 1ps

interface skit_out_if;
  logic                        valid;
  logic                        ready;
  logic [skit_pkg::ST_W-1:0]   status;
  logic [skit_pkg::POS_W-1:0]  found_position;
  logic [skit_pkg::USE_W-1:0]  entries_in_use;

  modport source (output valid, status, found_position, entries_in_use, input ready);
  modport sink   (input valid, status, found_position, entries_in_use, output ready);
endinterface

/* sv/skit_ctrl.sv */
`timescale 1ns / 1ps

module skit_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  skit_pkg::stat_t  stat,
  output skit_pkg::cmd_t   cmd
);

  skit_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skit_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skit_pkg::S_IDLE: begin
        if (in_valid) state_nxt = skit_pkg::S_PREP;
      end
      skit_pkg::S_PREP: begin
        if (!(stat.is_lookup || stat.is_insert || stat.is_delete) || stat.key_bad) begin
          state_nxt = skit_pkg::S_FINISH;
        end else begin
          state_nxt = skit_pkg::S_SRCH;
        end
      end
      skit_pkg::S_SRCH: begin
        state_nxt = stat.lo_lt_hi ? skit_pkg::S_SRCH_CMP : skit_pkg::S_CHK;
      end
      skit_pkg::S_SRCH_CMP: state_nxt = skit_pkg::S_SRCH;
      skit_pkg::S_CHK: begin
        if (stat.is_insert) begin
          if (stat.hit || stat.full) begin
            state_nxt = skit_pkg::S_FINISH;
          end else if (stat.ins_has_shift) begin
            state_nxt = skit_pkg::S_INS_SHIFT;
          end else begin
            state_nxt = skit_pkg::S_INS_PUT;
          end
        end else if (stat.is_delete && stat.hit && stat.del_has_shift) begin
          state_nxt = skit_pkg::S_DEL_SHIFT;
        end else begin
          state_nxt = skit_pkg::S_FINISH;
        end
      end
      skit_pkg::S_INS_SHIFT: begin
        if (!stat.ins_more) state_nxt = skit_pkg::S_INS_PUT;
      end
      skit_pkg::S_INS_PUT: state_nxt = skit_pkg::S_FINISH;
      skit_pkg::S_DEL_SHIFT: begin
        if (!stat.del_more) state_nxt = skit_pkg::S_FINISH;
      end
      skit_pkg::S_FINISH: begin
        if (!stat.out_busy) state_nxt = skit_pkg::S_IDLE;
      end
      default: state_nxt = skit_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd             = '0;
    cmd.status_code = skit_pkg::ST_OK;
    in_ready        = 1'b0;
    case (state_r)
      skit_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      skit_pkg::S_PREP: begin
        if ((stat.is_lookup || stat.is_insert || stat.is_delete) && stat.key_bad) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = skit_pkg::ST_RANGE;
        end
      end
      skit_pkg::S_SRCH: begin
        if (stat.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
        end else begin
          cmd.chk_rd = 1'b1;
        end
      end
      skit_pkg::S_SRCH_CMP: cmd.srch_upd = 1'b1;
      skit_pkg::S_CHK: begin
        if (stat.is_lookup) begin
          if (stat.hit) begin
            cmd.take_pos = 1'b1;
          end else begin
            cmd.set_status  = 1'b1;
            cmd.status_code = skit_pkg::ST_NOT_FOUND;
          end
        end else if (stat.is_insert) begin
          if (stat.hit) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = skit_pkg::ST_DUPLICATE;
          end else if (stat.full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = skit_pkg::ST_FULL;
          end else if (stat.ins_has_shift) begin
            cmd.ins_start = 1'b1;
          end
        end else begin
          if (!stat.hit) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = skit_pkg::ST_NOT_FOUND;
          end else begin
            cmd.take_pos = 1'b1;
            if (stat.del_has_shift) begin
              cmd.del_start = 1'b1;
            end else begin
              cmd.dec_count = 1'b1;
            end
          end
        end
      end
      skit_pkg::S_INS_SHIFT: cmd.ins_step = 1'b1;
      skit_pkg::S_INS_PUT:   cmd.ins_put  = 1'b1;
      skit_pkg::S_DEL_SHIFT: begin
        cmd.del_step  = 1'b1;
        cmd.dec_count = !stat.del_more;
      end
      skit_pkg::S_FINISH: cmd.emit = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

/* sv/skit_dp.sv */
`timescale 1ns / 1ps

module skit_dp #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  skit_pkg::cmd_t               cmd,
  output skit_pkg::stat_t              stat,
  input  logic [skit_pkg::MODE_W-1:0]  in_mode,
  input  logic [skit_pkg::KEY_W-1:0]   in_search_key,
  input  logic [skit_pkg::POS_W-1:0]   in_record_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [skit_pkg::ST_W-1:0]    out_status,
  output logic [skit_pkg::POS_W-1:0]   out_found_position,
  output logic [skit_pkg::USE_W-1:0]   out_entries_in_use
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int CX = CW + 1;
  localparam int EW = skit_pkg::KEY_W + skit_pkg::POS_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // entry = {key, position}
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_data_r;

  logic [skit_pkg::MODE_W-1:0] mode_r;
  logic [skit_pkg::KEY_W-1:0]  key_r;
  logic [skit_pkg::POS_W-1:0]  rpos_r;
  logic [CW-1:0]               lo_r, hi_r, ptr_r, count_r;
  skit_pkg::status_t           res_status_r;
  logic [skit_pkg::POS_W-1:0]  res_fpos_r;

  logic                        out_valid_r;
  logic [skit_pkg::ST_W-1:0]   out_status_r;
  logic [skit_pkg::POS_W-1:0]  out_fpos_r;
  logic [skit_pkg::USE_W-1:0]  out_use_r;

  logic [CW-1:0]               mid;
  logic [CW-1:0]               rd_idx;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic                        wr_en;
  logic [EW-1:0]               wr_data;
  logic [skit_pkg::KEY_W-1:0]  rd_key;
  logic [skit_pkg::POS_W-1:0]  rd_pos;
  logic [CX-1:0]               lo_x, ptr_x, count_x;
  logic [CW+skit_pkg::USE_W-1:0] count_use;

  assign rd_key  = rd_data_r[EW-1:skit_pkg::POS_W];
  assign rd_pos  = rd_data_r[skit_pkg::POS_W-1:0];
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_x    = {1'b0, lo_r};
  assign ptr_x   = {1'b0, ptr_r};
  assign count_x = {1'b0, count_r};

  // read address select
  always_comb begin
    rd_idx = lo_r;
    if (cmd.srch_rd) begin
      rd_idx = mid;
    end else if (cmd.chk_rd) begin
      rd_idx = lo_r;
    end else if (cmd.ins_start) begin
      rd_idx = count_r - CW'(1);
    end else if (cmd.ins_step) begin
      rd_idx = ptr_r - CW'(2);
    end else if (cmd.del_start) begin
      rd_idx = lo_r + CW'(1);
    end else if (cmd.del_step) begin
      rd_idx = ptr_r + CW'(2);
    end
  end
  assign rd_addr = rd_idx[AW-1:0];

  assign wr_en   = cmd.ins_step || cmd.ins_put || cmd.del_step;
  assign wr_addr = cmd.ins_put ? lo_r[AW-1:0] : ptr_r[AW-1:0];
  assign wr_data = cmd.ins_put ? {key_r, rpos_r} : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
    end else begin
      if (cmd.accept) begin
        lo_r <= '0;
        hi_r <= count_r;
      end else if (cmd.srch_upd) begin
        if (rd_key < key_r) begin
          lo_r <= mid + CW'(1);
        end else begin
          hi_r <= mid;
        end
      end
      if (cmd.ins_put) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dec_count) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r       <= in_mode;
      key_r        <= in_search_key;
      rpos_r       <= in_record_position;
      res_status_r <= skit_pkg::ST_OK;
      res_fpos_r   <= '0;
    end else begin
      if (cmd.set_status) res_status_r <= cmd.status_code;
      if (cmd.take_pos)   res_fpos_r   <= rd_pos;
    end
    if (cmd.ins_start) begin
      ptr_r <= count_r;
    end else if (cmd.ins_step) begin
      ptr_r <= ptr_r - CW'(1);
    end else if (cmd.del_start) begin
      ptr_r <= lo_r;
    end else if (cmd.del_step) begin
      ptr_r <= ptr_r + CW'(1);
    end
  end

  // output register
  assign count_use = {{skit_pkg::USE_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_fpos_r   <= res_fpos_r;
      out_use_r    <= count_use[skit_pkg::USE_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_fpos_r;
  assign out_entries_in_use = out_use_r;

  // status to controller
  always_comb begin
    stat.is_lookup     = (mode_r == skit_pkg::MODE_LOOKUP);
    stat.is_insert     = (mode_r == skit_pkg::MODE_INSERT);
    stat.is_delete     = (mode_r == skit_pkg::MODE_DELETE);
    stat.key_bad       = (key_r < skit_pkg::KEY_LOW) || (key_r > skit_pkg::KEY_HIGH);
    stat.lo_lt_hi      = (lo_r < hi_r);
    stat.hit           = (lo_r < count_r) && (rd_key == key_r);
    stat.full          = (count_r == DEPTH_C);
    stat.ins_has_shift = (count_r > lo_r);
    stat.ins_more      = (ptr_x > lo_x + CX'(1));
    stat.del_has_shift = (lo_x + CX'(1) < count_x);
    stat.del_more      = (ptr_x + CX'(2) < count_x);
    stat.out_busy      = out_valid_r && !out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above table depth");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= hi_r)
    else $error("search window inverted");

  a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_put |-> (count_r < DEPTH_C))
    else $error("insert into full table");

  a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec_count |-> (count_r != '0) && !cmd.ins_put)
    else $error("delete from empty table");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_ready))
    else $error("result overwrites pending transfer");

endmodule

/* sv/sorted_key_index_table_core.sv */
`timescale 1ns / 1ps
// Sequencing: one item at a time. Every mode runs a binary search of at most
//   ceil(log2(count+1)) steps and a check read; insert then shifts each entry at or
//   above the slot up and writes the new entry, delete shifts each entry above the hit
//   down; a bad key or unused mode skips straight to the result.
// The next input is taken only once the result sits in the output register.
// Reset: rst_n synchronous active low; clears count and handshake state, not the memory.

module sorted_key_index_table_core #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  skit_in_if.sink    in_chan,
  skit_out_if.source out_chan
);

  // Controller sequences each item: latch, range check, binary search
  // (read mid, compare), final check read, then a one-entry-per-cycle
  // shift through the memory for insert or delete, and a write of the new entry for insert.
  skit_pkg::cmd_t  cmd;
  skit_pkg::stat_t stat;
  logic            ctrl_in_ready;

  skit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ctrl_in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_chan.ready = ctrl_in_ready;

  // Datapath holds the sorted table memory, the search window, the shift
  // pointer, the entry count and the output register that parts the result
  // transfer from the work of the next item.
  skit_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_mode            (in_chan.mode),
    .in_search_key      (in_chan.search_key),
    .in_record_position (in_chan.record_position),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_status         (out_chan.status),
    .out_found_position (out_chan.found_position),
    .out_entries_in_use (out_chan.entries_in_use)
  );

endmodule
